>>> src/moving_average_filter_top_assert.svh
// Assertion macros shared by the moving average filter modules.
`ifndef MOVING_AVERAGE_FILTER_TOP_ASSERT_SVH
`define MOVING_AVERAGE_FILTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define MAF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define MAF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MAF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`define MAF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/maf_pkg.sv
// Package with the shared types and constants of the moving average filter.
package maf_pkg;

  localparam int CFG_LEN_W = 7;
  localparam int LEN_RESET = 10;

  typedef struct packed {
    logic cfg_wr;
    logic load;
    logic rd;
    logic upd;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

endpackage

>>> src/maf_ram.sv
// Generic single-port-write, registered-read RAM.
module maf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] ram_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      ram_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= ram_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/maf_datapath.sv
// Datapath of the moving average filter: window ring, running sum and serial divider.
`include "moving_average_filter_top_assert.svh"

module maf_datapath #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  maf_pkg::cmd_t                 cmd,
  output maf_pkg::sts_t                 sts,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [maf_pkg::CFG_LEN_W-1:0] cfg_window_len,
  output logic signed [SAMPLE_BITS-1:0] out_mean
);

  import maf_pkg::*;

  localparam int PTR_W    = $clog2(WINDOW_MAX);
  localparam int LEN_W    = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W    = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int CNT_W    = $clog2(SUM_W);
  localparam int CMP_W    = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
  localparam int LEN_INIT = (LEN_RESET > WINDOW_MAX) ? WINDOW_MAX : LEN_RESET;
  localparam int PROD_W   = SAMPLE_BITS + LEN_W + 1;

  logic signed [SAMPLE_BITS-1:0] sample_r, fill_r, fill_nxt, mean_r;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic [LEN_W-1:0]              ptr_r, ptr_nxt, len_r, len_nxt;
  logic                          first_lap_r, first_lap_nxt, primed_r, primed_nxt;
  logic [SUM_W-1:0]              quo_r, quo_nxt;
  logic [LEN_W-1:0]              rem_r, rem_nxt;
  logic                          neg_r, neg_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;

  logic signed [SAMPLE_BITS-1:0]     ram_rdata, old_val;
  logic signed [PROD_W-1:0]          prime_prod;
  logic signed [SUM_W-1:0]           upd_sum;
  logic [SUM_W-1:0]                  sum_abs;
  logic [LEN_W-1:0]                  ptr_inc;
  logic [CMP_W-1:0]                  cfg_ext, cfg_sat;
  logic [LEN_W:0]                    trial, trial_diff;
  logic                              trial_fits;
  logic [SUM_W-1:0]                  quo_signed;

  maf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.upd && primed_r),
    .waddr (ptr_r[PTR_W-1:0]),
    .wdata (sample_r),
    .re    (cmd.rd),
    .raddr (ptr_r[PTR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign old_val    = first_lap_r ? fill_r : ram_rdata;
  assign prime_prod = PROD_W'(sample_r) * PROD_W'($signed({1'b0, len_r}));
  assign upd_sum    = sum_r + SUM_W'(sample_r) - SUM_W'(old_val);
  assign sum_abs    = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign ptr_inc    = ptr_r + LEN_W'(1);

  assign cfg_ext = CMP_W'(cfg_window_len);
  always_comb begin
    cfg_sat = cfg_ext;
    if (cfg_ext == '0) begin
      cfg_sat = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(WINDOW_MAX)) begin
      cfg_sat = CMP_W'(WINDOW_MAX);
    end
  end

  assign trial      = {rem_r, quo_r[SUM_W-1]};
  assign trial_fits = trial >= {1'b0, len_r};
  assign trial_diff = trial - {1'b0, len_r};
  assign quo_signed = neg_r ? (~quo_r + SUM_W'(1)) : quo_r;

  always_comb begin
    len_nxt       = len_r;
    sum_nxt       = sum_r;
    ptr_nxt       = ptr_r;
    first_lap_nxt = first_lap_r;
    primed_nxt    = primed_r;
    fill_nxt      = fill_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    if (cmd.cfg_wr) begin
      len_nxt       = LEN_W'(cfg_sat);
      sum_nxt       = '0;
      ptr_nxt       = '0;
      first_lap_nxt = 1'b1;
      primed_nxt    = 1'b0;
    end
    if (cmd.upd) begin
      if (!primed_r) begin
        primed_nxt    = 1'b1;
        first_lap_nxt = 1'b1;
        fill_nxt      = sample_r;
        ptr_nxt       = '0;
        sum_nxt       = SUM_W'(prime_prod);
      end else begin
        sum_nxt = upd_sum;
        if (ptr_inc >= len_r) begin
          ptr_nxt       = '0;
          first_lap_nxt = 1'b0;
        end else begin
          ptr_nxt = ptr_inc;
        end
      end
    end
    if (cmd.div_load) begin
      quo_nxt = sum_abs;
      rem_nxt = '0;
      neg_nxt = sum_r[SUM_W-1];
      cnt_nxt = '0;
    end
    if (cmd.div_step) begin
      quo_nxt = {quo_r[SUM_W-2:0], trial_fits};
      rem_nxt = trial_fits ? trial_diff[LEN_W-1:0] : trial[LEN_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LEN_W'(LEN_INIT);
      sum_r       <= '0;
      ptr_r       <= '0;
      first_lap_r <= 1'b1;
      primed_r    <= 1'b0;
      fill_r      <= '0;
      cnt_r       <= '0;
    end else begin
      len_r       <= len_nxt;
      sum_r       <= sum_nxt;
      ptr_r       <= ptr_nxt;
      first_lap_r <= first_lap_nxt;
      primed_r    <= primed_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    if (cmd.load) begin
      sample_r <= in_sample;
    end
    if (cmd.out_load) begin
      mean_r <= quo_signed[SAMPLE_BITS-1:0];
    end
  end

  assign sts.div_last = cnt_r == CNT_W'(SUM_W - 1);
  assign out_mean     = mean_r;

  `MAF_ASSERT_IMPLY(a_ptr_in_window, clk, rst_n, primed_r, ptr_r < len_r,
                    "Ring pointer left the window.")
  `MAF_ASSERT_IMPLY(a_empty_sum_zero, clk, rst_n, !primed_r, sum_r == '0,
                    "Running sum is not zero while the window is empty.")
  `MAF_ASSERT_IMPLY(a_rem_below_len, clk, rst_n, cmd.div_step, rem_r < len_r,
                    "Divider remainder reached the window length.")

endmodule

>>> src/maf_ctrl.sv
// Controller state machine of the moving average filter.
`include "moving_average_filter_top_assert.svh"

module maf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  output maf_pkg::cmd_t cmd,
  input  maf_pkg::sts_t sts
);

  import maf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_UPDATE = 6'b000100,
    S_LOAD   = 6'b001000,
    S_DIV    = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign cfg_ready = state_r == S_IDLE;
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;

  assign cmd.cfg_wr   = cfg_valid && cfg_ready;
  assign cmd.load     = in_valid && in_ready;
  assign cmd.rd       = state_r == S_READ;
  assign cmd.upd      = state_r == S_UPDATE;
  assign cmd.div_load = state_r == S_LOAD;
  assign cmd.div_step = state_r == S_DIV;
  assign cmd.out_load = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_READ;
        end
      end
      S_READ:   state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_LOAD;
      S_LOAD:   state_nxt = S_DIV;
      S_DIV: begin
        if (sts.div_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (cmd.out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `MAF_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_r || out_ready,
                    "A result was loaded over one not yet transferred.")
  `MAF_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && in_ready, state_r == S_READ,
                   "An accepted sample did not start the window read.")
  `MAF_ASSERT_NEXT(a_div_ends, clk, rst_n, cmd.div_step && sts.div_last,
                   state_r == S_FINISH, "The divider did not hand over its quotient.")

endmodule

>>> src/moving_average_filter_top.sv
// Each sample transfer yields one mean transfer. In order, the block accepts a sample, reads the
// ring RAM, updates the running sum, loads the divider, runs the bit-serial divider by window_len
// at one quotient bit per cycle for the SUM_W quotient bits (22 with the default SUM_W,
// SAMPLE_BITS + log2 WINDOW_MAX) and registers the result; it takes no new sample before then. A
// finished mean waits in the output register until transferred; the next mean waits while that
// register is still full. Writing window_len (0 reads as 1, values above WINDOW_MAX saturate)
// restarts the window, and the next sample fills the whole window.
module moving_average_filter_top #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_mean,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [maf_pkg::CFG_LEN_W-1:0] cfg_window_len
);

  import maf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  maf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  maf_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_sample      (in_sample),
    .cfg_window_len (cfg_window_len),
    .out_mean       (out_mean)
  );

endmodule
